FILE: design/sobel_edge_magnitude_rgb_defines.svh
// Assertion macros shared by the sobel edge magnitude design.
// Used by modules that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH
`ifndef SYNTH
// property must hold at every clock edge out of reset
`define SEM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sem assertion failed");
// condition must never be seen out of reset
`define SEM_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("sem forbidden condition seen");
`else
`define SEM_ASSERT(name, prop)
`define SEM_NEVER(name, cond)
`endif
`endif

FILE: design/sem_pkg.sv
// Package for the sobel edge magnitude block: constants, codes and queue entry type.
// No dependencies.
package sem_pkg;

  localparam int MaxWidthDefault  = 1024;
  localparam int MaxHeightDefault = 4096;

  localparam int WidthRegW   = 11;
  localparam int HeightRegW  = 13;
  localparam int CfgIndexW   = 2;
  localparam int CfgDataW    = 13;
  localparam int WidthReset  = 1024;
  localparam int HeightReset = 768;

  localparam int ChanW  = 8;
  localparam int PixW   = 3 * ChanW;
  localparam int MagMax = 255;

  // register indexes on the configuration port
  typedef enum logic [CfgIndexW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1
  } cfg_index_e;

  // input operation codes
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic {
    F_IDLE,
    F_WR
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SQ,
    B_ROOT,
    B_OUT
  } back_state_e;

  // one window snapshot plus border masks, front to back
  typedef struct packed {
    logic [8:0][PixW-1:0] win;
    logic                 top_out;
    logic                 bot_out;
    logic                 left_out;
    logic                 right_out;
    logic                 last;
  } entry_t;

endpackage

FILE: design/sem_front.sv
// Front end: input and config ports, line stores, 3x3 window and frame position.
// Depends on sem_pkg.
module sem_front #(
  parameter int MAX_WIDTH  = sem_pkg::MaxWidthDefault,
  parameter int MAX_HEIGHT = sem_pkg::MaxHeightDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           operation_i,
  input  logic [sem_pkg::ChanW-1:0]      in_red_i,
  input  logic [sem_pkg::ChanW-1:0]      in_green_i,
  input  logic [sem_pkg::ChanW-1:0]      in_blue_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sem_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [sem_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                           push_o,
  output sem_pkg::entry_t                entry_o,
  input  logic                           full_i
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int RowW = $clog2(MAX_HEIGHT);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int NW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int KW   = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);
  localparam int PixW = sem_pkg::PixW;

  sem_pkg::front_state_e state_q, state_d;

  logic [sem_pkg::WidthRegW-1:0]  width_q;
  logic [sem_pkg::HeightRegW-1:0] height_q;
  logic [WW-1:0]                  eff_w;
  logic [HW-1:0]                  eff_h;
  logic [NW-1:0]                  npix_q;
  logic [KW-1:0]                  k_q;
  logic [ColW-1:0]                col_q;
  logic [ColW-1:0]                ocol_q;
  logic [RowW-1:0]                orow_q;
  logic [8:0][PixW-1:0]           win_q;
  logic [8:0][PixW-1:0]           win_n;

  logic                           op_q;
  logic [PixW-1:0]                pix_in_q;
  logic [PixW-1:0]                pix_w;
  logic [PixW-1:0]                rd_up_q;
  logic [PixW-1:0]                rd_mid_q;
  logic [PixW-1:0]                up_mem  [MAX_WIDTH];
  logic [PixW-1:0]                mid_mem [MAX_WIDTH];

  logic          accept;
  logic          cfg_wr;
  logic          leave;
  logic [KW-1:0] wp1;
  logic [KW-1:0] p;
  logic          have_out;
  logic          overrun;
  logic          emit;
  logic          last;

  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // registers clamped into their legal range
  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = HW'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_q);
    end
  end

  // frame position of this item
  assign wp1      = KW'(eff_w) + KW'(1);
  assign p        = k_q - wp1;
  assign have_out = k_q >= wp1;
  assign overrun  = have_out && (p >= KW'(npix_q));
  assign emit     = have_out && !overrun;
  assign last     = emit && (p == KW'(npix_q) - KW'(1));
  assign pix_w    = (op_q == sem_pkg::OP_DRAIN || k_q >= KW'(npix_q)) ? '0 : pix_in_q;

  // window shifted by one column
  always_comb begin
    win_n[0] = win_q[1];
    win_n[1] = win_q[2];
    win_n[2] = rd_up_q;
    win_n[3] = win_q[4];
    win_n[4] = win_q[5];
    win_n[5] = rd_mid_q;
    win_n[6] = win_q[7];
    win_n[7] = win_q[8];
    win_n[8] = pix_w;
  end

  assign leave  = (state_q == sem_pkg::F_WR) && (!emit || !full_i);
  assign push_o = (state_q == sem_pkg::F_WR) && emit && !full_i;

  always_comb begin
    entry_o.win       = win_n;
    entry_o.top_out   = orow_q == '0;
    entry_o.bot_out   = int'(orow_q) == int'(eff_h) - 1;
    entry_o.left_out  = ocol_q == '0;
    entry_o.right_out = int'(ocol_q) == int'(eff_w) - 1;
    entry_o.last      = last;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sem_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and ready
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      sem_pkg::F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = sem_pkg::F_WR;
        end
      end
      sem_pkg::F_WR: begin
        if (leave) begin
          state_d = sem_pkg::F_IDLE;
        end
      end
      default: state_d = sem_pkg::F_IDLE;
    endcase
  end

  // beat payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= operation_i;
      pix_in_q <= {in_red_i, in_green_i, in_blue_i};
    end
  end

  // line stores: read on accept, write back when the item retires
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_up_q  <= up_mem[col_q];
      rd_mid_q <= mid_mem[col_q];
    end
    if (leave) begin
      up_mem[col_q]  <= rd_mid_q;
      mid_mem[col_q] <= pix_w;
    end
  end

  // config registers, counters and window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sem_pkg::WidthRegW'(sem_pkg::WidthReset);
      height_q <= sem_pkg::HeightRegW'(sem_pkg::HeightReset);
      npix_q   <= '0;
      k_q      <= '0;
      col_q    <= '0;
      ocol_q   <= '0;
      orow_q   <= '0;
      win_q    <= '0;
    end else begin
      npix_q <= NW'(eff_w) * NW'(eff_h);
      if (cfg_wr) begin
        unique case (cfg_index_i)
          sem_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[sem_pkg::WidthRegW-1:0];
          sem_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
        if (cfg_index_i == sem_pkg::CFG_WIDTH || cfg_index_i == sem_pkg::CFG_HEIGHT) begin
          k_q    <= '0;
          col_q  <= '0;
          ocol_q <= '0;
          orow_q <= '0;
          win_q  <= '0;
        end
      end else if (leave) begin
        win_q <= overrun ? '0 : win_n;
        if (overrun || last) begin
          k_q    <= '0;
          col_q  <= '0;
          ocol_q <= '0;
          orow_q <= '0;
        end else begin
          k_q   <= k_q + KW'(1);
          col_q <= (int'(col_q) + 1 >= int'(eff_w)) ? '0 : col_q + ColW'(1);
          if (emit) begin
            if (int'(ocol_q) + 1 >= int'(eff_w)) begin
              ocol_q <= '0;
              orow_q <= orow_q + RowW'(1);
            end else begin
              ocol_q <= ocol_q + ColW'(1);
            end
          end
        end
      end
    end
  end

endmodule

FILE: design/sem_fifo.sv
// Two-entry queue of window snapshots between front and back.
// Depends on sem_pkg and the assertion macro header.
`include "sobel_edge_magnitude_rgb_defines.svh"
module sem_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sem_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sem_pkg::entry_t entry_o
);

  sem_pkg::entry_t slot_q [2];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      count_q;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign entry_o = slot_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  `SEM_NEVER(a_no_overflow, push_i && full_o && !pop_i)
  `SEM_NEVER(a_no_underflow, pop_i && empty_o)
  `SEM_ASSERT(a_count_range, count_q != 2'd3)

endmodule

FILE: design/sem_back.sv
// Back end: Sobel gradients, squared magnitude and bit-serial square root per channel.
// Depends on sem_pkg.
module sem_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  sem_pkg::entry_t           entry_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [sem_pkg::ChanW-1:0] out_red_o,
  output logic [sem_pkg::ChanW-1:0] out_green_o,
  output logic [sem_pkg::ChanW-1:0] out_blue_o,
  output logic                      frame_last_o
);

  localparam int ChanW = sem_pkg::ChanW;
  localparam int GW    = ChanW + 3;
  localparam int SqW   = 2 * GW;
  localparam int SatLimit = sem_pkg::MagMax * sem_pkg::MagMax;

  sem_pkg::back_state_e state_q, state_d;

  logic [ChanW-1:0]        v      [3][9];
  logic signed [GW-1:0]    gx     [3];
  logic signed [GW-1:0]    gy     [3];
  logic signed [GW-1:0]    gx_q   [3];
  logic signed [GW-1:0]    gy_q   [3];
  logic [SqW-1:0]          sq_q   [3];
  logic [ChanW-1:0]        root_q [3];
  logic [ChanW-1:0]        trial  [3];
  logic [2*ChanW-1:0]      tsq    [3];
  logic [2:0]              bit_q;
  logic                    last_q;
  logic                    out_valid_q;
  logic [ChanW-1:0]        out_q  [3];
  logic                    load_out;

  // masked neighbors, per channel
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          v[ch][r*3+c] = entry_i.win[r*3+c][sem_pkg::PixW-1-ch*ChanW -: ChanW];
          if ((r == 0 && entry_i.top_out) || (r == 2 && entry_i.bot_out) ||
              (c == 0 && entry_i.left_out) || (c == 2 && entry_i.right_out)) begin
            v[ch][r*3+c] = '0;
          end
        end
      end
    end
  end

  // gradients
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      gx[ch] = GW'(v[ch][2]) + GW'({v[ch][5], 1'b0}) + GW'(v[ch][8])
             - GW'(v[ch][0]) - GW'({v[ch][3], 1'b0}) - GW'(v[ch][6]);
      gy[ch] = GW'(v[ch][6]) + GW'({v[ch][7], 1'b0}) + GW'(v[ch][8])
             - GW'(v[ch][0]) - GW'({v[ch][1], 1'b0}) - GW'(v[ch][2]);
    end
  end

  // root trial for the current bit
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      trial[ch] = root_q[ch] | (ChanW'(1) << bit_q);
      tsq[ch]   = trial[ch] * trial[ch];
    end
  end

  assign pop_o    = (state_q == sem_pkg::B_IDLE) && !empty_i;
  assign load_out = (state_q == sem_pkg::B_OUT) && (!out_valid_q || out_ready_i);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sem_pkg::B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sem_pkg::B_IDLE: if (!empty_i) state_d = sem_pkg::B_SQ;
      sem_pkg::B_SQ:   state_d = sem_pkg::B_ROOT;
      sem_pkg::B_ROOT: if (bit_q == '0) state_d = sem_pkg::B_OUT;
      sem_pkg::B_OUT:  if (load_out) state_d = sem_pkg::B_IDLE;
      default:         state_d = sem_pkg::B_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      sem_pkg::B_IDLE: begin
        if (!empty_i) begin
          gx_q   <= gx;
          gy_q   <= gy;
          last_q <= entry_i.last;
        end
      end
      sem_pkg::B_SQ: begin
        // operands sign-extended to the full square width
        for (int ch = 0; ch < 3; ch++) begin
          sq_q[ch]   <= SqW'(gx_q[ch]) * SqW'(gx_q[ch]) + SqW'(gy_q[ch]) * SqW'(gy_q[ch]);
          root_q[ch] <= '0;
        end
      end
      sem_pkg::B_ROOT: begin
        for (int ch = 0; ch < 3; ch++) begin
          if (SqW'(tsq[ch]) <= sq_q[ch]) begin
            root_q[ch] <= trial[ch];
          end
        end
      end
      sem_pkg::B_OUT: begin
        if (load_out) begin
          for (int ch = 0; ch < 3; ch++) begin
            out_q[ch] <= (sq_q[ch] >= SqW'(SatLimit)) ? ChanW'(sem_pkg::MagMax) : root_q[ch];
          end
          frame_last_o <= last_q;
        end
      end
      default: ;
    endcase
  end

  // bit counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == sem_pkg::B_SQ) begin
        bit_q <= 3'(ChanW - 1);
      end else if (state_q == sem_pkg::B_ROOT) begin
        bit_q <= bit_q - 3'd1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];

endmodule

FILE: design/sobel_edge_magnitude_rgb.sv
// Sobel edge magnitude, RGB, 3x3 kernel, zero padding at the image border.
// Input channel (in_valid_i/in_ready_o) takes one pixel or drain beat in raster
// order; output channel (out_valid_o/out_ready_i) gives one magnitude beat per
// pixel, frame_last_o marking the final pixel of the frame. A result appears
// once image_width+1 further beats have been taken; drain beats flush the tail.
// The front end reads the line stores as it takes a beat and writes them back
// before it takes the next one. The back end pops an entry only when idle, then
// runs gradient, square, 8 root iterations and output load, which sets the
// sustained rate. A two-entry queue lets both halves stall on their own.
// Config port (cfg_valid_i/cfg_ready_o): index 0 width, index 1 height; a
// write to either restarts the frame. Write only while no beat is in flight.
// Reset: width 1024, height 768, frame restarted; line stores are not cleared.
// When the receiver stalls, the result holds in the output register, the back
// end waits, the queue fills and then the input channel stalls.
// Depends on sem_pkg, sem_front, sem_fifo and sem_back.
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH  = sem_pkg::MaxWidthDefault,
  parameter int MAX_HEIGHT = sem_pkg::MaxHeightDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [sem_pkg::ChanW-1:0]     in_red_i,
  input  logic [sem_pkg::ChanW-1:0]     in_green_i,
  input  logic [sem_pkg::ChanW-1:0]     in_blue_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sem_pkg::ChanW-1:0]     out_red_o,
  output logic [sem_pkg::ChanW-1:0]     out_green_o,
  output logic [sem_pkg::ChanW-1:0]     out_blue_o,
  output logic                          frame_last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sem_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [sem_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic            push;
  logic            full;
  logic            pop;
  logic            empty;
  sem_pkg::entry_t entry_in;
  sem_pkg::entry_t entry_out;

  sem_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .entry_o     (entry_in),
    .full_i      (full)
  );

  sem_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (entry_out)
  );

  sem_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .entry_i      (entry_out),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .frame_last_o (frame_last_o)
  );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for sobel_edge_magnitude_rgb: directed frames, then random ones.
// Keeps its own line stores and window to predict every magnitude beat. Depends on sem_pkg.
module tb_top;

  localparam int          LineDepth   = 1024;
  localparam int          RowLimit    = 4096;
  localparam int          DrainCycles = 40;
  localparam longint      CycleLimit  = 2000000;
  localparam logic [1:0]  CfgSpareLo  = 2'd2;
  localparam logic [1:0]  CfgSpareHi  = 2'd3;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } mag_beat_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic                          operation_i = sem_pkg::OP_PIXEL;
  logic [sem_pkg::ChanW-1:0]     in_red_i = '0;
  logic [sem_pkg::ChanW-1:0]     in_green_i = '0;
  logic [sem_pkg::ChanW-1:0]     in_blue_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [sem_pkg::ChanW-1:0]     out_red_o;
  logic [sem_pkg::ChanW-1:0]     out_green_o;
  logic [sem_pkg::ChanW-1:0]     out_blue_o;
  logic                          frame_last_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [sem_pkg::CfgIndexW-1:0] cfg_index_i = sem_pkg::CFG_WIDTH;
  logic [sem_pkg::CfgDataW-1:0]  cfg_data_i = '0;

  sobel_edge_magnitude_rgb dut (.*);

  // predictor state
  logic [sem_pkg::PixW-1:0] upper_row [LineDepth];
  logic [sem_pkg::PixW-1:0] middle_row [LineDepth];
  logic [sem_pkg::PixW-1:0] win [9];
  longint          beat_count;
  int              col_ptr;
  int unsigned     width_reg;
  int unsigned     height_reg;
  mag_beat_t       pending_mag [$];

  int     errors = 0;
  int     beats_sent = 0;
  bit     quiet = 1'b0;
  longint cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // timeout guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("sobel_edge_magnitude_rgb regression: fail");
      $finish;
    end
  end

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stalls
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      stall_left <= gap_len();
      out_ready_i <= 1'b1;
    end
  end

  function automatic void restart_frame();
    beat_count = 0;
    col_ptr = 0;
    foreach (win[i]) win[i] = '0;
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg < 1) return 1;
    if (width_reg > LineDepth) return LineDepth;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < 1) return 1;
    if (height_reg > RowLimit) return RowLimit;
    return height_reg;
  endfunction

  function automatic logic [7:0] root_sat(int unsigned v);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = sem_pkg::MagMax;
    if (v >= sem_pkg::MagMax * sem_pkg::MagMax) return 8'(sem_pkg::MagMax);
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo[7:0];
  endfunction

  // one accepted beat through the predicted line stores and window
  function automatic void sobel_predict(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    longint    w;
    longint    h;
    longint    npix;
    longint    k;
    longint    p;
    longint    cr;
    longint    cc;
    logic [sem_pkg::PixW-1:0] pix;
    int        col;
    int        gx;
    int        gy;
    int        v;
    mag_beat_t res;
    logic [7:0] mag [3];
    w = eff_width();
    h = eff_height();
    npix = w * h;
    k = beat_count;
    pix = (op == sem_pkg::OP_PIXEL && k < npix) ? {r, g, b} : '0;
    col = (col_ptr >= LineDepth) ? 0 : col_ptr;
    for (int i = 0; i < 3; i++) begin
      win[i*3] = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = upper_row[col];
    win[5] = middle_row[col];
    win[8] = pix;
    upper_row[col] = middle_row[col];
    middle_row[col] = pix;
    col_ptr = (col + 1 >= w) ? 0 : col + 1;
    beat_count = k + 1;
    if (k < w + 1) return;
    p = k - w - 1;
    if (p >= npix) begin
      restart_frame();
      return;
    end
    cr = p / w;
    cc = p % w;
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      for (int rr = 0; rr < 3; rr++) begin
        if (cr - 1 + rr < 0 || cr - 1 + rr >= h) continue;
        for (int c = 0; c < 3; c++) begin
          if (cc - 1 + c < 0 || cc - 1 + c >= w) continue;
          v = (win[rr*3+c] >> (16 - 8 * ch)) & 8'hFF;
          // Gx columns -1/0/+1 weighted 1-2-1 by row; Gy the transpose
          gx += v * (c - 1) * ((rr == 1) ? 2 : 1);
          gy += v * (rr - 1) * ((c == 1) ? 2 : 1);
        end
      end
      mag[ch] = root_sat(gx * gx + gy * gy);
    end
    res.red = mag[0];
    res.green = mag[1];
    res.blue = mag[2];
    res.last = (p == npix - 1);
    pending_mag.push_back(res);
    if (res.last) begin
      beat_count = 0;
      col_ptr = 0;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    mag_beat_t exp_beat;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_mag.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        exp_beat = pending_mag.pop_front();
        if (out_red_o !== exp_beat.red) begin
          $error("out_red exp %0d got %0d", exp_beat.red, out_red_o);
          errors++;
        end
        if (out_green_o !== exp_beat.green) begin
          $error("out_green exp %0d got %0d", exp_beat.green, out_green_o);
          errors++;
        end
        if (out_blue_o !== exp_beat.blue) begin
          $error("out_blue exp %0d got %0d", exp_beat.blue, out_blue_o);
          errors++;
        end
        if (frame_last_o !== exp_beat.last) begin
          $error("frame_last exp %0d got %0d", exp_beat.last, frame_last_o);
          errors++;
        end
      end
    end
  end

  // send one beat; called at a falling edge, returns at a falling edge
  task automatic send_beat(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    in_valid_i <= 1'b1;
    operation_i <= op;
    in_red_i <= r;
    in_green_i <= g;
    in_blue_i <= b;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    sobel_predict(op, r, g, b);
    beats_sent++;
    @(negedge clk_i);
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_rand(logic op);
    send_beat(op, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // wait until every result is in and the pipe has drained; called at a falling edge
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_mag.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [sem_pkg::CfgIndexW-1:0] idx,
                           logic [sem_pkg::CfgDataW-1:0] data);
    wait_idle();
    in_valid_i <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    if (idx == sem_pkg::CFG_WIDTH) begin
      width_reg = data & 13'h7FF;
      restart_frame();
    end else if (idx == sem_pkg::CFG_HEIGHT) begin
      height_reg = data;
      restart_frame();
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    write_reg(sem_pkg::CFG_WIDTH, sem_pkg::CfgDataW'(w));
    write_reg(sem_pkg::CFG_HEIGHT, sem_pkg::CfgDataW'(h));
  endtask

  // whole frame plus tail; drain_pct puts drain beats at pixel positions
  task automatic send_frame(int unsigned w, int unsigned h, int drain_pct, bit pix_tail);
    for (int i = 0; i < w * h; i++)
      send_rand(($urandom_range(0, 99) < drain_pct) ? sem_pkg::OP_DRAIN : sem_pkg::OP_PIXEL);
    for (int i = 0; i < w + 1; i++)
      send_rand((pix_tail && $urandom_range(0, 1)) ? sem_pkg::OP_PIXEL : sem_pkg::OP_DRAIN);
  endtask

  // extreme pixel values, drain inside the image, pixels past the image
  task automatic test_small_frame_extremes();
    quiet = 1'b1;
    set_size(3, 3);
    send_beat(sem_pkg::OP_PIXEL, 8'hFF, 8'h00, 8'hFF);
    send_beat(sem_pkg::OP_PIXEL, 8'h00, 8'hFF, 8'h00);
    send_beat(sem_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_beat(sem_pkg::OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
    send_beat(sem_pkg::OP_PIXEL, 8'hFF, 8'h00, 8'h00);
    send_beat(sem_pkg::OP_PIXEL, 8'h00, 8'h00, 8'hFF);
    send_beat(sem_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_beat(sem_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
    send_beat(sem_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    for (int i = 0; i < 4; i++) send_beat(sem_pkg::OP_PIXEL, 8'hAA, 8'h55, 8'hFF);
    quiet = 1'b0;
  endtask

  // clamped sizes: zero, above the maximum, single pixel frames
  task automatic test_border_sizes();
    set_size(0, 0);
    send_beat(sem_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_beat(sem_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
    send_beat(sem_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
    set_size(1, 8191);
    for (int i = 0; i < 20; i++) send_rand(sem_pkg::OP_PIXEL);
    set_size(2047, 2);
    for (int i = 0; i < 1028; i++) send_rand(sem_pkg::OP_PIXEL);
    set_size(2, 4096);
    for (int i = 0; i < 30; i++) send_rand(sem_pkg::OP_PIXEL);
  endtask

  // writes to unused indexes must not restart the frame
  task automatic test_config_codes();
    set_size(4, 3);
    for (int i = 0; i < 6; i++) send_rand(sem_pkg::OP_PIXEL);
    write_reg(CfgSpareLo, sem_pkg::CfgDataW'($urandom));
    for (int i = 0; i < 3; i++) send_rand(sem_pkg::OP_PIXEL);
    write_reg(CfgSpareHi, sem_pkg::CfgDataW'($urandom));
    for (int i = 0; i < 3; i++) send_rand(sem_pkg::OP_PIXEL);
    for (int i = 0; i < 5; i++) send_rand(sem_pkg::OP_DRAIN);
  endtask

  // random small frames, some broken off, some back to back
  task automatic test_random_frames();
    int unsigned w;
    int unsigned h;
    int          roll;
    int          target;
    target = beats_sent + 40;
    while (beats_sent < target) begin
      roll = $urandom_range(0, 99);
      w = (roll < 5) ? 0 : $urandom_range(1, 8);
      h = (roll > 95) ? 0 : $urandom_range(1, 6);
      write_reg(sem_pkg::CFG_WIDTH, sem_pkg::CfgDataW'(w | ($urandom_range(0, 3) << 11)));
      write_reg(sem_pkg::CFG_HEIGHT, sem_pkg::CfgDataW'(h));
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      quiet = ($urandom_range(0, 9) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        for (int i = 0; i < $urandom_range(1, w * h + w); i++)
          send_rand($urandom_range(0, 1) ? sem_pkg::OP_PIXEL : sem_pkg::OP_DRAIN);
      end else begin
        repeat ($urandom_range(1, 3)) send_frame(w, h, 10, roll < 50);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    width_reg = sem_pkg::WidthReset;
    height_reg = sem_pkg::HeightReset;
    foreach (upper_row[i]) upper_row[i] = '0;
    foreach (middle_row[i]) middle_row[i] = '0;
    restart_frame();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_small_frame_extremes();
    test_border_sizes();
    test_config_codes();
    test_random_frames();
    wait_idle();
    if (errors == 0 && pending_mag.size() == 0) begin
      $display("sobel_edge_magnitude_rgb regression: pass");
    end else begin
      $display("sobel_edge_magnitude_rgb regression: fail");
    end
    $finish;
  end
endmodule

FILE: sobel_edge_magnitude_rgb.f
+incdir+design
design/sem_pkg.sv
design/sem_front.sv
design/sem_fifo.sv
design/sem_back.sv
design/sobel_edge_magnitude_rgb.sv
dv/tb_top.sv
